[rtl/ptp_pkg.sv]
// shared types and constants for the point versus triangle plane test
// no dependencies; used by every module of the block
package ptp_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

    // load enables for a two-stage arithmetic unit
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_stage_en;

endpackage

[rtl/point_triangle_plane_test_core.sv]
// Takes one triangle request per clock while o_stall is low and returns one
// result per triangle, in order. The depth is set by the exact side test: the
// edge cross products (two stages) are dotted with the triangle normal
// through wide multipliers split into half-width partial products (two
// stages), then summed and sign tested. The distance path runs alongside in
// the same seven stages. A stall at the output holds the output register;
// earlier stages keep filling bubbles, so a new request is taken while a
// finished result waits. The user must write the query point through the
// configuration port only while the block is idle; the block does not check.
// depends on ptp_pkg, ptp_cross, ptp_split_mul
module point_triangle_plane_test_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,

    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_vert1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vert1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vert1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_vert2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vert2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vert2_z,
    input  logic signed [COORD_WIDTH-1:0]       i_vert3_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vert3_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vert3_z,
    input  logic signed [FRAC_BITS+1:0]         i_normal_x,
    input  logic signed [FRAC_BITS+1:0]         i_normal_y,
    input  logic signed [FRAC_BITS+1:0]         i_normal_z,

    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [COORD_WIDTH-1:0]       o_plane_distance,
    output logic                                o_inside_res
);

    localparam int CW   = COORD_WIDTH;
    localparam int NW   = FRAC_BITS + 2;
    localparam int D    = CW + 1;
    localparam int CRW  = 2 * D + 1;
    localparam int PRW  = 2 * CRW;
    localparam int DTW  = PRW + 2;
    localparam int DPW  = NW + D;
    localparam int AW   = DPW + 2;
    localparam int NST  = 7;

    localparam logic [AW-1:0] HALF    = AW'((64'd1 << FRAC_BITS) >> 1);
    localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW - 1){1'b0}}};

    // query point
    logic signed [CW-1:0] r_q [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptp_pkg::REG_QUERY_X: r_q[0] <= i_cfg_data;
                ptp_pkg::REG_QUERY_Y: r_q[1] <= i_cfg_data;
                ptp_pkg::REG_QUERY_Z: r_q[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NST:1] r_vld;
    logic [NST:1] w_rdy;

    always_comb begin
        w_rdy[NST] = !r_vld[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[1];
    assign o_valid = r_vld[NST];

    // stage 1: differences
    logic signed [CW-1:0] w_v1 [3];
    logic signed [CW-1:0] w_v2 [3];
    logic signed [CW-1:0] w_v3 [3];
    logic signed [NW-1:0] w_nrm [3];

    assign w_v1  = '{i_vert1_x, i_vert1_y, i_vert1_z};
    assign w_v2  = '{i_vert2_x, i_vert2_y, i_vert2_z};
    assign w_v3  = '{i_vert3_x, i_vert3_y, i_vert3_z};
    assign w_nrm = '{i_normal_x, i_normal_y, i_normal_z};

    logic signed [D-1:0]  r_e21 [3];
    logic signed [D-1:0]  r_e31 [3];
    logic signed [D-1:0]  r_e32 [3];
    logic signed [D-1:0]  r_dq1 [3];
    logic signed [D-1:0]  r_dq2 [3];
    logic signed [NW-1:0] r_nrm [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_e21[k] <= D'(w_v2[k]) - D'(w_v1[k]);
                r_e31[k] <= D'(w_v3[k]) - D'(w_v1[k]);
                r_e32[k] <= D'(w_v3[k]) - D'(w_v2[k]);
                r_dq1[k] <= D'(r_q[k]) - D'(w_v1[k]);
                r_dq2[k] <= D'(r_q[k]) - D'(w_v2[k]);
                r_nrm[k] <= w_nrm[k];
            end
        end
    end

    // stages 2 and 3: triangle normal and edge cross products
    ptp_pkg::t_stage_en w_en_cross;
    ptp_pkg::t_stage_en w_en_dot;

    assign w_en_cross = '{en_mul: w_rdy[2], en_sum: w_rdy[3]};
    assign w_en_dot   = '{en_mul: w_rdy[4], en_sum: w_rdy[5]};

    logic signed [CRW-1:0] w_tn [3];
    logic signed [CRW-1:0] w_cs [3][3];

    ptp_cross #(.IN_W(D)) u_cross_n (
        .i_clk (i_clk),
        .i_en  (w_en_cross),
        .i_a   (r_e21),
        .i_b   (r_e31),
        .o_c   (w_tn)
    );

    // edge from second to third vertex, seen from the second vertex
    ptp_cross #(.IN_W(D)) u_cross_e1 (
        .i_clk (i_clk),
        .i_en  (w_en_cross),
        .i_a   (r_e32),
        .i_b   (r_dq2),
        .o_c   (w_cs[0])
    );

    // edge from first to third vertex; its opposite side faces minus normal
    ptp_cross #(.IN_W(D)) u_cross_e2 (
        .i_clk (i_clk),
        .i_en  (w_en_cross),
        .i_a   (r_e31),
        .i_b   (r_dq1),
        .o_c   (w_cs[1])
    );

    ptp_cross #(.IN_W(D)) u_cross_e3 (
        .i_clk (i_clk),
        .i_en  (w_en_cross),
        .i_a   (r_e21),
        .i_b   (r_dq1),
        .o_c   (w_cs[2])
    );

    // stages 4 and 5: edge cross products times triangle normal
    logic signed [PRW-1:0] w_prod [3][3];

    for (genvar e = 0; e < 3; e++) begin : g_edge
        for (genvar k = 0; k < 3; k++) begin : g_axis
            ptp_split_mul #(.W(CRW)) u_mul (
                .i_clk (i_clk),
                .i_en  (w_en_dot),
                .i_x   (w_cs[e][k]),
                .i_y   (w_tn[k]),
                .o_p   (w_prod[e][k])
            );
        end
    end

    // stage 6: dot sums
    logic signed [DTW-1:0] r_dot [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            for (int e = 0; e < 3; e++) begin
                r_dot[e] <= DTW'(w_prod[e][0]) + DTW'(w_prod[e][1]) + DTW'(w_prod[e][2]);
            end
        end
    end

    // distance path
    logic signed [DPW-1:0] r_dp [3];
    logic signed [AW-1:0]  r_acc;
    logic signed [AW-1:0]  n_rnd;
    logic signed [CW-1:0]  n_dist;
    logic signed [CW-1:0]  r_dist4;
    logic signed [CW-1:0]  r_dist5;
    logic signed [CW-1:0]  r_dist6;
    logic signed [CW-1:0]  r_dist7;
    logic                  r_inside7;
    logic                  n_inside;

    always_comb begin
        n_rnd = (r_acc + $signed(HALF)) >>> FRAC_BITS;
        if (&n_rnd[AW-1:CW-1] || ~|n_rnd[AW-1:CW-1]) begin
            n_dist = n_rnd[CW-1:0];
        end else if (n_rnd[AW-1]) begin
            n_dist = SAT_MIN;
        end else begin
            n_dist = SAT_MAX;
        end
    end

    // strictly on the vertex side of every edge
    assign n_inside = !r_dot[0][DTW-1] && (|r_dot[0]) &&
                      r_dot[1][DTW-1] &&
                      !r_dot[2][DTW-1] && (|r_dot[2]);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_dp[k] <= r_nrm[k] * r_dq1[k];
            end
        end
        if (w_rdy[3]) begin
            r_acc <= AW'(r_dp[0]) + AW'(r_dp[1]) + AW'(r_dp[2]);
        end
        if (w_rdy[4]) begin
            r_dist4 <= n_dist;
        end
        if (w_rdy[5]) begin
            r_dist5 <= r_dist4;
        end
        if (w_rdy[6]) begin
            r_dist6 <= r_dist5;
        end
        if (w_rdy[7]) begin
            r_dist7   <= r_dist6;
            r_inside7 <= n_inside;
        end
    end

    assign o_plane_distance = r_dist7;
    assign o_inside_res     = r_inside7;

    // checks
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (&r_vld))
    ) else $error("input stalled while the pipeline has room");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_plane_distance) && $stable(o_inside_res))
    ) else $error("stalled result lost or changed");

    a_result_advances: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !(o_valid && i_stall)) |=> o_valid
    ) else $error("finished request did not reach the output");

endmodule

[rtl/ptp_cross.sv]
// exact 3d cross product of two signed vectors, two register stages
// products in the first stage, component differences in the second
// depends on ptp_pkg (t_stage_en)
module ptp_cross #(
    parameter int IN_W = 25
) (
    input  logic                   i_clk,
    input  ptp_pkg::t_stage_en     i_en,
    input  logic signed [IN_W-1:0] i_a [3],
    input  logic signed [IN_W-1:0] i_b [3],
    output logic signed [2*IN_W:0] o_c [3]
);

    localparam int PW = 2 * IN_W;
    localparam int RW = PW + 1;

    logic signed [PW-1:0] r_pp [3];
    logic signed [PW-1:0] r_pm [3];
    logic signed [RW-1:0] r_c  [3];

    always_ff @(posedge i_clk) begin
        if (i_en.en_mul) begin
            r_pp[0] <= i_a[1] * i_b[2];
            r_pm[0] <= i_a[2] * i_b[1];
            r_pp[1] <= i_a[2] * i_b[0];
            r_pm[1] <= i_a[0] * i_b[2];
            r_pp[2] <= i_a[0] * i_b[1];
            r_pm[2] <= i_a[1] * i_b[0];
        end
        if (i_en.en_sum) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= RW'(r_pp[k]) - RW'(r_pm[k]);
            end
        end
    end

    assign o_c = r_c;

endmodule

[rtl/ptp_split_mul.sv]
// wide signed multiplier split into four partial products
// partial products in the first stage, recombination in the second
// depends on ptp_pkg (t_stage_en)
module ptp_split_mul #(
    parameter int W = 51
) (
    input  logic                  i_clk,
    input  ptp_pkg::t_stage_en    i_en,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    output logic signed [2*W-1:0] o_p
);

    localparam int S  = (W + 1) / 2;
    localparam int H  = W - S;
    localparam int PW = 2 * W;
    localparam int HH = 2 * H;
    localparam int HL = H + S + 1;
    localparam int LL = 2 * S;

    logic signed [H-1:0] w_xh;
    logic signed [H-1:0] w_yh;
    logic        [S-1:0] w_xl;
    logic        [S-1:0] w_yl;
    logic signed [S:0]   w_xl_s;
    logic signed [S:0]   w_yl_s;

    logic signed [HH-1:0] r_hh;
    logic signed [HL-1:0] r_hl;
    logic signed [HL-1:0] r_lh;
    logic        [LL-1:0] r_ll;
    logic signed [PW-1:0] r_p;

    assign w_xh   = i_x[W-1:S];
    assign w_yh   = i_y[W-1:S];
    assign w_xl   = i_x[S-1:0];
    assign w_yl   = i_y[S-1:0];
    assign w_xl_s = {1'b0, w_xl};
    assign w_yl_s = {1'b0, w_yl};

    always_ff @(posedge i_clk) begin
        if (i_en.en_mul) begin
            r_hh <= w_xh * w_yh;
            r_hl <= w_xh * w_yl_s;
            r_lh <= w_xl_s * w_yh;
            r_ll <= w_xl * w_yl;
        end
        if (i_en.en_sum) begin
            r_p <= (PW'(r_hh) <<< LL) + ((PW'(r_hl) + PW'(r_lh)) <<< S) + PW'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule
